// ----- design/hcsa_pkg.sv -----
// shared constants and types for the hall current sensor averager
package hcsa_pkg;

    localparam int SENS_W     = 20;
    localparam int OUT_W      = 19;
    localparam int SUM_W      = 36;
    localparam int CNT_W      = 16;
    localparam int HALF_W     = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int OUT_DATA_W = 40;

    // (3.3 V / 2) scaled to milliamps from microvolts per amp
    localparam logic [HALF_W-1:0] HALF_VREF_SCALED = 31'd1650000000;
    localparam logic [OUT_W-1:0]  CURRENT_LIMIT_MA = 19'd200000;
    localparam logic [SENS_W-1:0] SENS_RESET       = 20'd100000;
    localparam logic [CNT_W-1:0]  NAVG_RESET       = 16'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SENSITIVITY = 2'd0,
        CFG_FEEDBACK    = 2'd1,
        CFG_SAMPLES     = 2'd2
    } cfg_reg_t;

endpackage

// ----- design/hcsa_div.sv -----
// restoring divider, one quotient bit per cycle, unsigned operands
module hcsa_div #(
    parameter int DVD_W = 42,
    parameter int DVS_W = 31
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [$clog2(DVD_W+1)-1:0]    steps,
    input  logic [DVD_W-1:0]              dividend,
    input  logic [DVS_W-1:0]              divisor,
    output logic [DVD_W-1:0]              quotient,
    output logic                          done
);

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0]  quo_reg, quo_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic [STEP_W-1:0] left_reg, left_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [DVS_W:0] rem_shift;
    logic [DVS_W:0] rem_sub;
    logic           fits;

    // dividend bits leave from the top while quotient bits enter at the bottom
    assign rem_shift = {rem_reg, quo_reg[DVD_W-1]};
    assign rem_sub   = rem_shift - {1'b0, dvs_reg};
    assign fits      = ~rem_sub[DVS_W];

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        left_next = left_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            left_next = steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[DVD_W-2:0], fits};
            rem_next  = fits ? rem_sub[DVS_W-1:0] : rem_shift[DVS_W-1:0];
            left_next = left_reg - 1'b1;
            if (left_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            left_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            dvs_reg  <= dvs_next;
            left_reg <= left_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ----- design/hall_current_sensor_averager.sv -----
// top level: ratiometric hall sensor code to milliamps, with block averaging
//
// Each word carries a sensor code and a supply code; the block returns one word per sample
// with the instant current, the held block average, an update flag and a saturation flag.
// One shared multiplier forms numerator and denominator in turn and one shared
// restoring divider (one quotient bit per cycle) does both the current and the average
// division. The current division takes most of a sample's time; a sample that closes a
// block adds the average division. Input is not accepted while a sample is in work; a
// finished word waits in the output register and does not hold off the next input.
// Configuration writes are always accepted and take effect at once.
module hall_current_sensor_averager #(
    parameter int ADC_BITS = 10
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // sample_code, supply_code, zero fill
    input  logic [((2*ADC_BITS+7)/8)*8-1:0]      s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // instant_current_ma, average_current_ma, average_updated, saturated
    output logic [hcsa_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [hcsa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hcsa_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import hcsa_pkg::*;

    localparam int SUP_W  = ADC_BITS + 1;
    localparam int DIFF_W = ADC_BITS + 2;
    localparam int NUM_W  = HALF_W + SUP_W;
    localparam int DEN_W  = SENS_W + SUP_W;
    localparam int DVD_W  = NUM_W;
    localparam int DVS_W  = DEN_W;
    localparam int STEP_W = $clog2(DVD_W + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_NUM,
        ST_MUL_DEN,
        ST_DEN_CHK,
        ST_DIV_CUR,
        ST_ACCUM,
        ST_AVG_START,
        ST_DIV_AVG,
        ST_OUT
    } state_t;

    state_t                  state_reg, state_next;
    logic [SENS_W-1:0]       sens_reg, sens_next;
    logic                    fb_reg, fb_next;
    logic [CNT_W-1:0]        navg_reg, navg_next;
    logic                    neg_reg, neg_next;
    logic [SUP_W-1:0]        mag_reg, mag_next;
    logic [SUP_W-1:0]        sup_reg, sup_next;
    logic [NUM_W-1:0]        num_reg, num_next;
    logic [DEN_W-1:0]        den_reg, den_next;
    logic [OUT_W-1:0]        cur_reg, cur_next;
    logic                    sat_reg, sat_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [OUT_W-1:0]        held_reg, held_next;
    logic                    upd_reg, upd_next;
    logic                    out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0]   out_data_reg, out_data_next;

    logic [ADC_BITS-1:0]     sample;
    logic [ADC_BITS-1:0]     supply;
    logic [SUP_W-1:0]        sup_eff;
    logic [DIFF_W-1:0]       diff;
    logic [DIFF_W-1:0]       diff_abs;

    logic [HALF_W-1:0]       mul_a;
    logic [SUP_W-1:0]        mul_b;
    logic [NUM_W-1:0]        mul_p;

    logic                    div_start;
    logic [STEP_W-1:0]       div_steps;
    logic [DVD_W-1:0]        div_dividend;
    logic [DVS_W-1:0]        div_divisor;
    logic [DVD_W-1:0]        div_quot;
    logic                    div_done;

    logic                    q_over;
    logic [OUT_W-1:0]        q_mag;
    logic [SUM_W-1:0]        sum_add;
    logic [CNT_W:0]          cnt_inc;
    logic [CNT_W-1:0]        n_eff;
    logic                    close_blk;
    logic [SUM_W-1:0]        sum_abs;
    logic [OUT_W-1:0]        avg_mag;

    assign sample   = s_axis_tdata[ADC_BITS-1:0];
    assign supply   = s_axis_tdata[2*ADC_BITS-1:ADC_BITS];
    assign sup_eff  = fb_reg ? {1'b0, supply} : {1'b1, {ADC_BITS{1'b0}}};
    assign diff     = {1'b0, sample, 1'b0} - {1'b0, sup_eff};
    assign diff_abs = diff[DIFF_W-1] ? -diff : diff;

    // shared multiplier: numerator first, then denominator
    always_comb
    begin
        if (state_reg == ST_MUL_DEN)
        begin
            mul_a = HALF_W'(sens_reg);
            mul_b = sup_reg;
        end
        else
        begin
            mul_a = HALF_VREF_SCALED;
            mul_b = mag_reg;
        end
    end

    assign mul_p = NUM_W'(mul_a) * NUM_W'(mul_b);

    assign sum_abs = sum_reg[SUM_W-1] ? -sum_reg : sum_reg;

    // shared divider operands
    always_comb
    begin
        if (state_reg == ST_AVG_START)
        begin
            div_start    = 1'b1;
            div_steps    = STEP_W'(SUM_W);
            div_dividend = {sum_abs, {(DVD_W-SUM_W){1'b0}}};
            div_divisor  = DVS_W'(count_reg);
        end
        else
        begin
            div_start    = (state_reg == ST_DEN_CHK) && (den_reg != '0);
            div_steps    = STEP_W'(DVD_W);
            div_dividend = num_reg;
            div_divisor  = den_reg;
        end
    end

    hcsa_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .steps    (div_steps),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quot),
        .done     (div_done)
    );

    assign q_over    = div_quot > DVD_W'(CURRENT_LIMIT_MA);
    assign q_mag     = q_over ? CURRENT_LIMIT_MA : div_quot[OUT_W-1:0];
    assign avg_mag   = div_quot[OUT_W-1:0];
    assign sum_add   = sum_reg + {{(SUM_W-OUT_W){cur_reg[OUT_W-1]}}, cur_reg};
    assign cnt_inc   = {1'b0, count_reg} + 1'b1;
    assign n_eff     = (navg_reg == '0) ? NAVG_RESET : navg_reg;
    assign close_blk = cnt_inc >= {1'b0, n_eff};

    always_comb
    begin
        state_next     = state_reg;
        sens_next      = sens_reg;
        fb_next        = fb_reg;
        navg_next      = navg_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        sup_next       = sup_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        cur_next       = cur_reg;
        sat_next       = sat_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        held_next      = held_reg;
        upd_next       = upd_reg;
        out_valid_next = out_valid_reg & ~m_axis_tready;
        out_data_next  = out_data_reg;

        if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_SENSITIVITY: sens_next = cfg_data[SENS_W-1:0];
                CFG_FEEDBACK:    fb_next   = cfg_data[0];
                CFG_SAMPLES:     navg_next = cfg_data[CNT_W-1:0];
                default:         ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    neg_next   = diff[DIFF_W-1];
                    mag_next   = diff_abs[SUP_W-1:0];
                    sup_next   = sup_eff;
                    upd_next   = 1'b0;
                    state_next = ST_MUL_NUM;
                end
            end
            ST_MUL_NUM:
            begin
                num_next   = mul_p;
                state_next = ST_MUL_DEN;
            end
            ST_MUL_DEN:
            begin
                den_next   = mul_p[DEN_W-1:0];
                state_next = ST_DEN_CHK;
            end
            ST_DEN_CHK:
            begin
                // zero divisor pins the current to the limit on the numerator's side
                if (den_reg == '0)
                begin
                    cur_next   = neg_reg ? -CURRENT_LIMIT_MA : CURRENT_LIMIT_MA;
                    sat_next   = 1'b1;
                    state_next = ST_ACCUM;
                end
                else
                begin
                    state_next = ST_DIV_CUR;
                end
            end
            ST_DIV_CUR:
            begin
                if (div_done)
                begin
                    cur_next   = neg_reg ? -q_mag : q_mag;
                    sat_next   = q_over;
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM:
            begin
                sum_next   = sum_add;
                count_next = cnt_inc[CNT_W-1:0];
                state_next = close_blk ? ST_AVG_START : ST_OUT;
            end
            ST_AVG_START:
            begin
                state_next = ST_DIV_AVG;
            end
            ST_DIV_AVG:
            begin
                if (div_done)
                begin
                    held_next  = sum_reg[SUM_W-1] ? -avg_mag : avg_mag;
                    sum_next   = '0;
                    count_next = '0;
                    upd_next   = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {sat_reg, upd_reg, held_reg, cur_reg};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sens_reg      <= SENS_RESET;
            fb_reg        <= 1'b0;
            navg_reg      <= NAVG_RESET;
            neg_reg       <= 1'b0;
            mag_reg       <= '0;
            sup_reg       <= '0;
            num_reg       <= '0;
            den_reg       <= '0;
            cur_reg       <= '0;
            sat_reg       <= 1'b0;
            sum_reg       <= '0;
            count_reg     <= '0;
            held_reg      <= '0;
            upd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            sens_reg      <= sens_next;
            fb_reg        <= fb_next;
            navg_reg      <= navg_next;
            neg_reg       <= neg_next;
            mag_reg       <= mag_next;
            sup_reg       <= sup_next;
            num_reg       <= num_next;
            den_reg       <= den_next;
            cur_reg       <= cur_next;
            sat_reg       <= sat_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            held_reg      <= held_next;
            upd_reg       <= upd_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign cfg_ready     = 1'b1;

endmodule

// ----- tb/sv/tb_hall_current_sensor_averager.sv -----
// self-checking testbench for the hall current sensor averager
module tb_hall_current_sensor_averager;

    import hcsa_pkg::*;

    localparam int ADC_BITS      = 10;
    localparam int S_DATA_W      = ((2*ADC_BITS+7)/8)*8;
    localparam int TOTAL_SAMPLES = 650;
    localparam int SETTLE_CYCLES = 120;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int IDLE_PCT      = 17;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // same layout as m_axis_tdata, lowest field last
    typedef struct packed {
        logic                    saturated;
        logic                    updated;
        logic signed [OUT_W-1:0] average;
        logic signed [OUT_W-1:0] instant;
    } reading_t;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_SAMPLE,
        ROW_KNOWN
    } row_kind_t;

    typedef struct packed {
        row_kind_t               kind;
        logic [CFG_IDX_W-1:0]    index;
        logic [CFG_DATA_W-1:0]   value;
        logic [ADC_BITS-1:0]     sample_code;
        logic [ADC_BITS-1:0]     supply_code;
        int                      exp_instant;
        int                      exp_average;
        int                      exp_updated;
        int                      exp_saturated;
    } stim_row_t;

    localparam int LIM = 200000;

    // write rows carry index/value, sample rows carry codes, known rows also the answer
    stim_row_t directed_rows [0:33] = '{
        '{ROW_KNOWN,  CFG_SENSITIVITY, 20'd0,       10'd512,  10'd0,    0,    0,    1, 0},
        '{ROW_SAMPLE, CFG_SENSITIVITY, 20'd0,       10'd0,    10'd0,    0,    0,    0, 0},
        '{ROW_SAMPLE, CFG_SENSITIVITY, 20'd0,       10'd1023, 10'd1023, 0,    0,    0, 0},
        '{ROW_WRITE,  CFG_SENSITIVITY, 20'd1000,    10'd0,    10'd0,    0,    0,    0, 0},
        '{ROW_KNOWN,  CFG_SENSITIVITY, 20'd0,       10'd0,    10'd512,  -LIM, -LIM, 1, 1},
        '{ROW_KNOWN,  CFG_SENSITIVITY, 20'd0,       10'd1023, 10'd0,    LIM,  LIM,  1, 1},
        '{ROW_WRITE,  CFG_FEEDBACK,    20'd1,       10'd0,    10'd0,    0,    0,    0, 0},
        // zero supply code: sign of numerator picks the rail
        '{ROW_KNOWN,  CFG_SENSITIVITY, 20'd0,       10'd512,  10'd0,    LIM,  LIM,  1, 1},
        '{ROW_KNOWN,  CFG_SENSITIVITY, 20'd0,       10'd0,    10'd0,    LIM,  LIM,  1, 1},
        '{ROW_KNOWN,  CFG_SENSITIVITY, 20'd0,       10'd0,    10'd1,    -LIM, -LIM, 1, 1},
        '{ROW_WRITE,  CFG_SENSITIVITY, 20'hFFFFF,   10'd0,    10'd0,    0,    0,    0, 0},
        '{ROW_SAMPLE, CFG_SENSITIVITY, 20'd0,       10'd1023, 10'd1,    0,    0,    0, 0},
        '{ROW_SAMPLE, CFG_SENSITIVITY, 20'd0,       10'd0,    10'd1023, 0,    0,    0, 0},
        '{ROW_KNOWN,  CFG_SENSITIVITY, 20'd0,       10'd511,  10'd1022, 0,    0,    1, 0},
        // zero sensitivity
        '{ROW_WRITE,  CFG_SENSITIVITY, 20'd0,       10'd0,    10'd0,    0,    0,    0, 0},
        '{ROW_KNOWN,  CFG_SENSITIVITY, 20'd0,       10'd300,  10'd1000, -LIM, -LIM, 1, 1},
        '{ROW_KNOWN,  CFG_SENSITIVITY, 20'd0,       10'd700,  10'd1000, LIM,  LIM,  1, 1},
        '{ROW_WRITE,  CFG_UNUSED,      20'hABCDE,   10'd0,    10'd0,    0,    0,    0, 0},
        '{ROW_KNOWN,  CFG_SENSITIVITY, 20'd0,       10'd512,  10'd1000, LIM,  LIM,  1, 1},
        '{ROW_WRITE,  CFG_SENSITIVITY, 20'd100000,  10'd0,    10'd0,    0,    0,    0, 0},
        '{ROW_WRITE,  CFG_SAMPLES,     20'd4,       10'd0,    10'd0,    0,    0,    0, 0},
        '{ROW_SAMPLE, CFG_SENSITIVITY, 20'd0,       10'd900,  10'd1000, 0,    0,    0, 0},
        '{ROW_SAMPLE, CFG_SENSITIVITY, 20'd0,       10'd100,  10'd1020, 0,    0,    0, 0},
        '{ROW_SAMPLE, CFG_SENSITIVITY, 20'd0,       10'd1023, 10'd990,  0,    0,    0, 0},
        '{ROW_SAMPLE, CFG_SENSITIVITY, 20'd0,       10'd7,    10'd1001, 0,    0,    0, 0},
        '{ROW_WRITE,  CFG_SAMPLES,     20'd65535,   10'd0,    10'd0,    0,    0,    0, 0},
        '{ROW_SAMPLE, CFG_SENSITIVITY, 20'd0,       10'd1000, 10'd1000, 0,    0,    0, 0},
        '{ROW_SAMPLE, CFG_SENSITIVITY, 20'd0,       10'd3,    10'd1015, 0,    0,    0, 0},
        '{ROW_SAMPLE, CFG_SENSITIVITY, 20'd0,       10'd812,  10'd0,    0,    0,    0, 0},
        // block length lowered below the count: closes on the next word
        '{ROW_WRITE,  CFG_SAMPLES,     20'd2,       10'd0,    10'd0,    0,    0,    0, 0},
        '{ROW_SAMPLE, CFG_SENSITIVITY, 20'd0,       10'd640,  10'd1023, 0,    0,    0, 0},
        '{ROW_WRITE,  CFG_SAMPLES,     20'hF0000,   10'd0,    10'd0,    0,    0,    0, 0},
        '{ROW_SAMPLE, CFG_SENSITIVITY, 20'd0,       10'd222,  10'd512,  0,    0,    0, 0},
        '{ROW_WRITE,  CFG_FEEDBACK,    20'hFFFFE,   10'd0,    10'd0,    0,    0,    0, 0}
    };

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [S_DATA_W-1:0]     s_axis_tdata = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    // predictor copy of registers and accumulator
    logic [SENS_W-1:0]       sens_reg = SENS_RESET;
    logic                    feedback_on = 1'b0;
    logic [CNT_W-1:0]        block_len = NAVG_RESET;
    longint                  acc_sum = 0;
    int unsigned             acc_count = 0;
    longint                  held_avg = 0;

    reading_t                expected_readings [$];
    bit                      no_idle = 1'b0;
    int                      fail_count = 0;
    int                      samples_sent = 0;
    int                      words_checked = 0;
    int                      reg_writes = 0;
    int                      averages_seen = 0;
    int unsigned             cycle_count = 0;

    hall_current_sensor_averager #(
        .ADC_BITS(ADC_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        m_axis_tready <= rst_n && (no_idle || $urandom_range(99) >= IDLE_PCT);
    end

    function automatic reading_t predict_reading(input logic [ADC_BITS-1:0] sample_code,
                                                 input logic [ADC_BITS-1:0] supply_code);
        longint      supply;
        longint      num;
        longint      den;
        longint      cur;
        longint      limit;
        int unsigned n_eff;
        int unsigned cnt;
        reading_t    r;
        limit = longint'(CURRENT_LIMIT_MA);
        supply = feedback_on ? longint'(supply_code) : (longint'(1) << ADC_BITS);
        num = longint'(HALF_VREF_SCALED) * (2 * longint'(sample_code) - supply);
        den = longint'(sens_reg) * supply;
        r = '0;
        if (den == 0)
        begin
            cur = (num >= 0) ? limit : -limit;
            r.saturated = 1'b1;
        end
        else
        begin
            cur = num / den;
            if (cur > limit || cur < -limit)
            begin
                cur = (cur > 0) ? limit : -limit;
                r.saturated = 1'b1;
            end
        end
        acc_sum += cur;
        n_eff = (block_len == 0) ? 1 : block_len;
        cnt = acc_count + 1;
        if (cnt >= n_eff)
        begin
            held_avg = acc_sum / longint'(cnt);
            acc_sum = 0;
            acc_count = 0;
            r.updated = 1'b1;
        end
        else
        begin
            acc_count = cnt;
        end
        r.instant = cur[OUT_W-1:0];
        r.average = held_avg[OUT_W-1:0];
        return r;
    endfunction

    // every driving task starts on a falling edge, so no signal is driven twice in a step
    task automatic send_sample(input logic [ADC_BITS-1:0] sample_code,
                               input logic [ADC_BITS-1:0] supply_code,
                               input bit known, input reading_t given);
        reading_t predicted;
        @(negedge clk);
        cfg_valid <= 1'b0;
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= S_DATA_W'({supply_code, sample_code});
        do @(posedge clk); while (!s_axis_tready);
        predicted = predict_reading(sample_code, supply_code);
        expected_readings.push_back(known ? given : predicted);
        samples_sent++;
    endtask

    task automatic drain_readings();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        cfg_valid <= 1'b0;
        while (expected_readings.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        case (index)
            CFG_SENSITIVITY: sens_reg = value[SENS_W-1:0];
            CFG_FEEDBACK:    feedback_on = value[0];
            CFG_SAMPLES:     block_len = value[CNT_W-1:0];
            default:         ;
        endcase
        reg_writes++;
    endtask

    always @(posedge clk)
    begin : watch_output
        reading_t got;
        reading_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = reading_t'(m_axis_tdata);
            words_checked++;
            if (got.updated)
                averages_seen++;
            if (expected_readings.size() == 0)
            begin
                $error("output word with no reading pending: %h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = expected_readings.pop_front();
                if (got.instant !== want.instant)
                begin
                    $error("instant_current_ma: expected %0d, got %0d",
                           want.instant, got.instant);
                    fail_count++;
                end
                if (got.average !== want.average)
                begin
                    $error("average_current_ma: expected %0d, got %0d",
                           want.average, got.average);
                    fail_count++;
                end
                if (got.updated !== want.updated)
                begin
                    $error("average_updated: expected %0b, got %0b", want.updated, got.updated);
                    fail_count++;
                end
                if (got.saturated !== want.saturated)
                begin
                    $error("saturated: expected %0b, got %0b", want.saturated, got.saturated);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        reading_t              given;
        stim_row_t             row;
        int                    phase;
        int                    phase_len;
        logic [ADC_BITS-1:0]   sample_code;
        logic [ADC_BITS-1:0]   supply_code;
        logic [CFG_DATA_W-1:0] value;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < $size(directed_rows); i++)
        begin
            row = directed_rows[i];
            if (row.kind == ROW_WRITE)
            begin
                drain_readings();
                write_reg(row.index, row.value);
            end
            else
            begin
                given.instant = OUT_W'(row.exp_instant);
                given.average = OUT_W'(row.exp_average);
                given.updated = row.exp_updated[0];
                given.saturated = row.exp_saturated[0];
                send_sample(row.sample_code, row.supply_code, row.kind == ROW_KNOWN, given);
            end
        end
        // feedback off again: a zero supply code must be ignored
        send_sample(10'd200, 10'd0, 1'b0, '0);

        phase = 0;
        while (samples_sent < TOTAL_SAMPLES)
        begin
            drain_readings();
            no_idle = (phase == 3);
            if (phase == 0 || $urandom_range(99) < 70)
            begin
                case ($urandom_range(9))
                    0:       value = 20'd1000;
                    1:       value = 20'd1000000;
                    2:       value = 20'hFFFFF;
                    3:       value = 20'd0;
                    default: value = 20'($urandom_range(1000, 1000000));
                endcase
                write_reg(CFG_SENSITIVITY, value);
            end
            if (phase == 0 || $urandom_range(99) < 50)
            begin
                // upper bits of the word are junk and must be dropped
                value = 20'($urandom);
                value[0] = ($urandom_range(99) < 60);
                write_reg(CFG_FEEDBACK, value);
            end
            if (phase == 0 || $urandom_range(99) < 70)
            begin
                value = 20'($urandom);
                case ($urandom_range(9))
                    0:       value[CNT_W-1:0] = 16'd0;
                    1:       value[CNT_W-1:0] = 16'd65535;
                    2:       value[CNT_W-1:0] = 16'($urandom);
                    3:       value[CNT_W-1:0] = 16'($urandom_range(9, 40));
                    default: value[CNT_W-1:0] = 16'($urandom_range(1, 8));
                endcase
                write_reg(CFG_SAMPLES, value);
            end
            if ($urandom_range(9) == 0)
                write_reg(CFG_UNUSED, 20'($urandom));

            phase_len = no_idle ? 80 : $urandom_range(8, 40);
            repeat (phase_len)
            begin
                case ($urandom_range(9))
                    0:       sample_code = '0;
                    1:       sample_code = '1;
                    default: sample_code = ADC_BITS'($urandom);
                endcase
                case ($urandom_range(9))
                    0:       supply_code = '0;
                    1:       supply_code = '1;
                    2, 3, 4: supply_code = ADC_BITS'($urandom);
                    default: supply_code = ADC_BITS'($urandom_range(900, 1023));
                endcase
                send_sample(sample_code, supply_code, 1'b0, '0);
            end
            phase++;
        end

        drain_readings();
        no_idle = 1'b0;
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (expected_readings.size() != 0)
        begin
            $error("%0d readings never came out", expected_readings.size());
            fail_count++;
        end
        $display("%0d samples over %0d setting phases, %0d register writes", samples_sent,
                 phase, reg_writes);
        $display("%0d output words checked, %0d block averages, %0d failures", words_checked,
                 averages_seen, fail_count);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
